[rtl/rsc_pkg.sv]
package rsc_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int WORD_W      = 32;
    localparam int STEP_W      = $clog2(WORD_W);

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_VALUE     = 3'd1;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd2;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd3;
    localparam logic [2:0] STAT_DIVZERO   = 3'd4;
    localparam logic [2:0] STAT_QUIT      = 3'd5;
    localparam logic [2:0] STAT_STOPPED   = 3'd6;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_EQUAL = 8'h3d;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } t_alu_rsp;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_FIX,
        ALU_DONE
    } t_alu_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_RHS,
        S_RD_LHS,
        S_ALU,
        S_EQ,
        S_DONE
    } t_state;

endpackage

[rtl/rsc_alu.sv]
module rsc_alu
    import rsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output t_alu_rsp          o_rsp
);

    t_alu_state r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0] r_a, n_a;
    logic [WORD_W-1:0] r_b, n_b;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_res, n_res;
    logic              r_neg, n_neg;

    logic [WORD_W:0]   w_x, w_y;
    logic              w_sub;
    logic [WORD_W+1:0] w_sum;
    logic [WORD_W-1:0] w_mag_a, w_mag_b;
    logic              w_last;

    assign w_mag_a = i_a[WORD_W-1] ? (~i_a + WORD_W'(1)) : i_a;
    assign w_mag_b = i_b[WORD_W-1] ? (~i_b + WORD_W'(1)) : i_b;
    assign w_last  = (r_cnt == STEP_W'(WORD_W - 1));

    // shared add-subtract unit
    always_comb begin
        w_x   = {1'b0, i_a};
        w_y   = {1'b0, i_b};
        w_sub = (i_req.op == OP_SUB);
        case (r_state)
            ALU_MUL: begin
                w_x   = {1'b0, r_acc};
                w_y   = {1'b0, r_a};
                w_sub = 1'b0;
            end
            ALU_DIV: begin
                w_x   = {r_acc, r_b[WORD_W-1]};
                w_y   = {1'b0, r_a};
                w_sub = 1'b1;
            end
            ALU_FIX: begin
                w_x   = '0;
                w_y   = {1'b0, r_b};
                w_sub = r_neg;
            end
            default: begin
            end
        endcase
        w_sum = w_sub ? ({1'b0, w_x} - {1'b0, w_y}) : ({1'b0, w_x} + {1'b0, w_y});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        OP_MUL:  n_state = ALU_MUL;
                        OP_DIV:  n_state = ALU_DIV;
                        default: n_state = ALU_DONE;
                    endcase
                end
            end
            ALU_MUL:  if (w_last) n_state = ALU_DONE;
            ALU_DIV:  if (w_last) n_state = ALU_FIX;
            ALU_FIX:  n_state = ALU_DONE;
            ALU_DONE: n_state = ALU_IDLE;
            default:  n_state = ALU_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        n_a   = r_a;
        n_b   = r_b;
        n_acc = r_acc;
        n_res = r_res;
        n_neg = r_neg;
        case (r_state)
            ALU_IDLE: begin
                n_cnt = '0;
                if (i_req.start) begin
                    case (i_req.op)
                        OP_MUL: begin
                            n_a   = i_a;
                            n_b   = i_b;
                            n_acc = '0;
                        end
                        OP_DIV: begin
                            n_a   = w_mag_b;
                            n_b   = w_mag_a;
                            n_acc = '0;
                            n_neg = i_a[WORD_W-1] ^ i_b[WORD_W-1];
                        end
                        default: n_res = w_sum[WORD_W-1:0];
                    endcase
                end
            end
            ALU_MUL: begin
                n_cnt = r_cnt + STEP_W'(1);
                if (r_b[0]) n_acc = w_sum[WORD_W-1:0];
                n_a = {r_a[WORD_W-2:0], 1'b0};
                n_b = {1'b0, r_b[WORD_W-1:1]};
                if (w_last) n_res = r_b[0] ? w_sum[WORD_W-1:0] : r_acc;
            end
            ALU_DIV: begin
                n_cnt = r_cnt + STEP_W'(1);
                if (!w_sum[WORD_W+1]) begin
                    n_acc = w_sum[WORD_W-1:0];
                    n_b   = {r_b[WORD_W-2:0], 1'b1};
                end else begin
                    n_acc = w_x[WORD_W-1:0];
                    n_b   = {r_b[WORD_W-2:0], 1'b0};
                end
            end
            ALU_FIX: n_res = w_sum[WORD_W-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_res <= n_res;
        r_neg <= n_neg;
    end

    assign o_rsp.done   = (r_state == ALU_DONE);
    assign o_rsp.result = r_res;

endmodule

[rtl/rpn_stack_calculator_top.sv]
// Reverse Polish evaluator: one character per input transaction, exactly one result
// transaction per character. Digits push, + - * / pop two values and push the result
// (32-bit wrap, division truncates toward zero), = reports the top value and empties the
// stack, whitespace does nothing. A fault or an unknown character is reported once and the
// block then answers stopped until reset. The stack is a 128-entry single-port-write memory
// with a registered read and needs no clearing after reset. An operator has its right and
// left operands read from the stack in turn before the shared add-subtract unit works out
// the result; multiply and divide retire one bit per cycle in that unit, and a division by
// zero is reported without starting it.
// The block takes no new character while one is being worked on; a finished result waits in
// the output register so the next character can be taken before it is collected.
module rpn_stack_calculator_top
    import rsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char_code,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_value
);

    logic [WORD_W-1:0] r_stack [STACK_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_stopped, n_stopped;
    t_alu_op           r_op, n_op;
    logic [WORD_W-1:0] r_rhs, n_rhs;
    logic [2:0]        r_res_status, n_res_status;
    logic [WORD_W-1:0] r_res_value, n_res_value;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_status, n_out_status;
    logic [WORD_W-1:0] r_out_value, n_out_value;

    logic              w_we, w_re;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    logic [WORD_W-1:0] w_wdata;
    logic [CNT_W-1:0]  w_cnt_dec;
    logic              w_ws, w_digit, w_arith, w_eq, w_empty, w_full, w_load;
    t_alu_op           w_char_op;
    t_alu_req          w_alu_req;
    t_alu_rsp          w_alu_rsp;

    assign w_cnt_dec = r_count - CNT_W'(1);
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= CNT_W'(STACK_DEPTH));
    assign w_load    = !r_out_valid || i_ready;

    always_comb begin
        w_ws    = (i_char_code == CH_SPACE) || (i_char_code inside {[CH_TAB:CH_CR]});
        w_digit = i_char_code inside {[CH_ZERO:CH_NINE]};
        w_arith = i_char_code inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        w_eq    = (i_char_code == CH_EQUAL);
        case (i_char_code)
            CH_MINUS: w_char_op = OP_SUB;
            CH_STAR:  w_char_op = OP_MUL;
            CH_SLASH: w_char_op = OP_DIV;
            default:  w_char_op = OP_ADD;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DONE;
                    if (!r_stopped && !w_ws && !w_empty) begin
                        if (w_arith)   n_state = S_RD_RHS;
                        else if (w_eq) n_state = S_EQ;
                    end
                end
            end
            S_RD_RHS: n_state = w_empty ? S_DONE : S_RD_LHS;
            S_RD_LHS: begin
                if (r_op == OP_DIV && r_rhs == '0) n_state = S_DONE;
                else                               n_state = S_ALU;
            end
            S_ALU:    if (w_alu_rsp.done) n_state = S_DONE;
            S_EQ:     n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_stopped    = r_stopped;
        n_op         = r_op;
        n_rhs        = r_rhs;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_waddr      = r_count[IDX_W-1:0];
        w_raddr      = w_cnt_dec[IDX_W-1:0];
        w_wdata      = {{(WORD_W-4){1'b0}}, i_char_code[3:0]};
        w_alu_req    = '{start: 1'b0, op: r_op};
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res_status = STAT_OK;
                    n_res_value  = '0;
                    n_op         = w_char_op;
                    if (r_stopped) begin
                        n_res_status = STAT_STOPPED;
                    end else if (w_ws) begin
                        n_res_status = STAT_OK;
                    end else if (w_digit) begin
                        if (w_full) begin
                            n_res_status = STAT_OVERFLOW;
                            n_stopped    = 1'b1;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (w_arith || w_eq) begin
                        if (w_empty) begin
                            n_res_status = STAT_UNDERFLOW;
                            n_stopped    = 1'b1;
                        end else begin
                            w_re    = 1'b1;
                            n_count = w_eq ? '0 : w_cnt_dec;
                        end
                    end else begin
                        n_res_status = STAT_QUIT;
                        n_stopped    = 1'b1;
                    end
                end
            end
            S_RD_RHS: begin
                n_rhs = r_rd_data;
                if (w_empty) begin
                    n_res_status = STAT_UNDERFLOW;
                    n_stopped    = 1'b1;
                end else begin
                    w_re    = 1'b1;
                    n_count = w_cnt_dec;
                end
            end
            S_RD_LHS: begin
                if (r_op == OP_DIV && r_rhs == '0) begin
                    n_res_status = STAT_DIVZERO;
                    n_stopped    = 1'b1;
                end else begin
                    w_alu_req.start = 1'b1;
                end
            end
            S_ALU: begin
                w_wdata = w_alu_rsp.result;
                if (w_alu_rsp.done) begin
                    w_we         = 1'b1;
                    n_count      = r_count + CNT_W'(1);
                    n_res_status = STAT_OK;
                end
            end
            S_EQ: begin
                n_res_status = STAT_VALUE;
                n_res_value  = r_rd_data;
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                end
            end
            default: begin
            end
        endcase
    end

    rsc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_a     (r_rd_data),
        .i_b     (r_rhs),
        .o_rsp   (w_alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) r_stack[w_waddr] <= w_wdata;
        if (w_re) r_rd_data <= r_stack[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_rhs        <= n_rhs;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_value  = $signed(r_out_value);

`ifndef ASSERT_OFF
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_VALUE |-> o_value == '0)
        else $error("nonzero value with non-value status");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    a_alu_done_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.done |-> r_state == S_ALU)
        else $error("alu finished outside of alu wait");
`endif

endmodule
